/* rtl/sound_chip_timer_status_ports_assert.svh */
// Assertion macros for the sound chip timer and status port block.
// Needs nothing; included by the top level for its concurrent checks.
`ifndef SOUND_CHIP_TIMER_STATUS_PORTS_ASSERT_SVH
`define SOUND_CHIP_TIMER_STATUS_PORTS_ASSERT_SVH

// Same-cycle implication, checks off while reset is high.
`define SCTSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checks off while reset is high.
`define SCTSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sctsp_pkg.sv */
// Shared types, codes, widths and period functions for the sound chip
// timer and status port block. Depends on nothing.
package sctsp_pkg;

  localparam int MAX_TICK_CYCLES = 4000;

  localparam int CYC_W    = 12;
  localparam int SAT_W    = ($clog2(MAX_TICK_CYCLES + 1) > CYC_W) ?
                            $clog2(MAX_TICK_CYCLES + 1) : CYC_W;
  localparam int TA_W     = 10;
  localparam int TB_W     = 8;
  localparam int CNT_A_W  = 17;
  localparam int CNT_B_W  = 19;
  localparam int CNT_W    = CNT_B_W;
  localparam int UW       = CNT_W + 1;
  localparam int IDX_W    = $clog2(CYC_W);

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_TICK  = 2'd2,
    FN_HOST  = 2'd3
  } func_t;

  // Sound CPU ports
  localparam logic [7:0] PORT_CMD     = 8'h00;
  localparam logic [7:0] PORT_ADDR_LO = 8'h04;
  localparam logic [7:0] PORT_DATA_LO = 8'h05;
  localparam logic [7:0] PORT_ADDR_HI = 8'h06;
  localparam logic [7:0] PORT_DATA_HI = 8'h07;
  localparam logic [7:0] PORT_REPLY   = 8'h0C;
  localparam logic [7:0] PORT_TSTAT   = 8'h04;
  localparam logic [7:0] PORT_PSTAT   = 8'h06;

  // Register numbers behind the data ports
  localparam logic [7:0] REG_PB_CLR  = 8'h10;
  localparam logic [7:0] REG_PB_MASK = 8'h1C;
  localparam logic [7:0] REG_TA_HI   = 8'h24;
  localparam logic [7:0] REG_TA_LO   = 8'h25;
  localparam logic [7:0] REG_TB      = 8'h26;
  localparam logic [7:0] REG_TCTL    = 8'h27;
  localparam logic [7:0] REG_PB_SET  = 8'h00;

  localparam logic [7:0] PB_RESET    = 8'h3F;
  localparam logic [7:0] PB_ALL      = 8'h3F;
  localparam logic [7:0] REPLY_RESET = 8'h01;
  localparam logic [7:0] RD_NONE     = 8'hFF;

  typedef struct packed {
    logic [1:0] enables;
    logic       load_a;
    logic       load_b;
  } tmr_ctl_t;

  typedef struct packed {
    logic a;
    logic b;
  } tmr_flag_t;

  // 36 * (1024 - v) as shift and add
  function automatic logic [CNT_A_W-1:0] period_a_f(input logic [TA_W-1:0] v);
    logic [CNT_A_W-1:0] n;
    n = CNT_A_W'(11'd1024 - {1'b0, v});
    return (n << 5) + (n << 2);
  endfunction

  // 576 * (256 - v) as shift and add
  function automatic logic [CNT_B_W-1:0] period_b_f(input logic [TB_W-1:0] v);
    logic [CNT_B_W-1:0] n;
    n = CNT_B_W'(9'd256 - {1'b0, v});
    return (n << 9) + (n << 6);
  endfunction

  function automatic logic [CYC_W-1:0] sat_cycles(input logic [CYC_W-1:0] e);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(e);
    if (ext > SAT_W'(MAX_TICK_CYCLES)) return CYC_W'(MAX_TICK_CYCLES);
    return e;
  endfunction

endpackage

/* rtl/sound_chip_timer_status_ports.sv */
// Top level of the sound chip timer and status port block.
// Depends on sctsp_pkg, sctsp_regs, sctsp_timer_seq and the assertion header.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   input   | in_valid / in_ready  | func, port_number, data_byte, elapsed_cycles
//   output  | out_valid / out_ready| read_data, host_reply, nmi_request
//
// Port writes, reads and host commands go from accept through the done state
// to the output register. A tick runs, per enabled timer, a check and a
// decrement when it does not expire, or a check, one subtractor step per
// remainder bit of the 12-bit deficit and a reload when it does.
// Reset clears all control state and loads the latch reset values.
// in_ready is high whenever the item sequencer is idle; a finished item
// waits in the done state only while the output register still holds an
// untaken item.
`include "sound_chip_timer_status_ports_assert.svh"

module sound_chip_timer_status_ports (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [7:0]                   port_number,
  input  logic [7:0]                   data_byte,
  input  logic [sctsp_pkg::CYC_W-1:0]  elapsed_cycles,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   read_data,
  output logic [7:0]                   host_reply,
  output logic                         nmi_request
);
  import sctsp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_DONE = 3'b100
  } top_state_t;

  top_state_t           state;
  logic                 accept;
  logic                 is_tick;
  logic                 start_tick;
  logic                 reg_acc;
  logic                 seq_done;
  logic                 out_load;
  logic                 done_stall;
  logic                 seq_busy;
  logic [7:0]           rd;
  logic [7:0]           rd_hold;
  logic [7:0]           reply;
  logic                 nmi;
  tmr_ctl_t             ctl;
  tmr_flag_t            flag_set;
  logic [TA_W-1:0]      value_a;
  logic [TB_W-1:0]      value_b;

  // take a new item whenever the sequencer is idle
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign is_tick    = (func == FN_TICK);
  assign start_tick = accept && is_tick;
  assign reg_acc    = accept && !is_tick;

  // move the finished item out once the output register is free
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);

  // port decode and latches act at the accept edge
  sctsp_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .acc         (reg_acc),
    .func        (func),
    .port_number (port_number),
    .data_byte   (data_byte),
    .flag_set    (flag_set),
    .rd          (rd),
    .reply       (reply),
    .nmi         (nmi),
    .ctl         (ctl),
    .value_a     (value_a),
    .value_b     (value_b)
  );

  // timers advance over many cycles on the shared subtractor
  sctsp_timer_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start_tick),
    .elapsed_cycles (elapsed_cycles),
    .ctl            (ctl),
    .value_a        (value_a),
    .value_b        (value_b),
    .done           (seq_done),
    .flag_set       (flag_set)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // hold the read byte seen at accept; non-reads give all ones
            rd_hold <= rd;
            state   <= is_tick ? S_TICK : S_DONE;
          end
        end
        S_TICK: begin
          if (seq_done) state <= S_DONE;
        end
        S_DONE: begin
          // drop the item into the output register once it is free
          if (out_load) begin
            read_data   <= rd_hold;
            host_reply  <= reply;
            nmi_request <= nmi;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done_stall = (state == S_DONE) && out_valid && !out_ready;
  assign seq_busy   = seq_done || flag_set.a || flag_set.b;

  `SCTSP_ASSERT_NEXT(a_done_holds, clk, rst, done_stall, (state == S_DONE), "done not held")
  `SCTSP_ASSERT_NEXT(a_nontick_done, clk, rst, reg_acc, (state == S_DONE), "non-tick not done")
  `SCTSP_ASSERT_NOW(a_seq_done_tick, clk, rst, seq_busy, (state == S_TICK), "busy outside tick")

endmodule

/* rtl/sctsp_alu.sv */
// Shared subtractor of the timer sequencer: difference and borrow.
// Depends on sctsp_pkg for the unit width.
module sctsp_alu (
  input  logic [sctsp_pkg::UW-1:0] a,
  input  logic [sctsp_pkg::UW-1:0] b,
  output logic [sctsp_pkg::UW-1:0] diff,
  output logic                     borrow
);
  import sctsp_pkg::*;

  logic [UW:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[UW-1:0];
  assign borrow = full[UW];

endmodule

/* rtl/sctsp_regs.sv */
// Port decode and register file: address latches, timer values, enables,
// flags, playback flags and host latches. Depends on sctsp_pkg.
module sctsp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  logic [1:0]                   func,
  input  logic [7:0]                   port_number,
  input  logic [7:0]                   data_byte,
  input  sctsp_pkg::tmr_flag_t         flag_set,
  output logic [7:0]                   rd,
  output logic [7:0]                   reply,
  output logic                         nmi,
  output sctsp_pkg::tmr_ctl_t          ctl,
  output logic [sctsp_pkg::TA_W-1:0]   value_a,
  output logic [sctsp_pkg::TB_W-1:0]   value_b
);
  import sctsp_pkg::*;

  logic [7:0] addr_lo;
  logic [7:0] addr_hi;
  logic [1:0] enables;
  logic [1:0] flags;
  logic [1:0] flag_clr;
  logic [7:0] pb_flags;
  logic [7:0] cmd;
  logic       wr_lo;

  assign wr_lo = acc && (func == FN_WRITE) && (port_number == PORT_DATA_LO);

  // timer control write drops the selected flags
  assign flag_clr = (wr_lo && (addr_lo == REG_TCTL)) ? {data_byte[5], data_byte[4]} : 2'b00;

  always_comb begin
    ctl.enables = enables;
    ctl.load_a  = wr_lo && (addr_lo == REG_TCTL) && data_byte[2];
    ctl.load_b  = wr_lo && (addr_lo == REG_TCTL) && data_byte[3];
  end

  always_comb begin
    rd = RD_NONE;
    if (func == FN_READ) begin
      unique case (port_number)
        PORT_CMD:   rd = cmd;
        PORT_TSTAT: rd = {6'b0, flags};
        PORT_PSTAT: rd = pb_flags;
        default:    rd = RD_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_lo  <= '0;
      addr_hi  <= '0;
      value_a  <= '0;
      value_b  <= '0;
      enables  <= '0;
      flags    <= '0;
      pb_flags <= PB_RESET;
      cmd      <= '0;
      reply    <= REPLY_RESET;
      nmi      <= 1'b0;
    end else begin
      flags <= (flags | {flag_set.b, flag_set.a}) & ~flag_clr;
      if (acc) begin
        unique case (func)
          FN_WRITE: begin
            unique case (port_number)
              PORT_ADDR_LO: addr_lo <= data_byte;
              PORT_ADDR_HI: addr_hi <= data_byte;
              PORT_REPLY:   reply   <= data_byte;
              PORT_DATA_LO: begin
                unique case (addr_lo)
                  REG_PB_CLR:  if (data_byte[0]) pb_flags[7] <= 1'b0;
                  REG_PB_MASK: pb_flags <= pb_flags &
                                           ~{data_byte[7], 1'b0, data_byte[5:0]};
                  REG_TA_HI:   value_a[9:2] <= data_byte;
                  REG_TA_LO:   value_a[1:0] <= data_byte[1:0];
                  REG_TB:      value_b <= data_byte;
                  REG_TCTL:    enables <= data_byte[1:0];
                  default: ;
                endcase
              end
              PORT_DATA_HI: begin
                if (addr_hi == REG_PB_SET) begin
                  pb_flags <= pb_flags | (data_byte[7] ? PB_ALL :
                                          {2'b0, data_byte[5:0]});
                end
              end
              default: ;
            endcase
          end
          FN_READ: if (port_number == PORT_CMD) nmi <= 1'b0;
          FN_HOST: begin
            cmd <= data_byte;
            nmi <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/sctsp_timer_seq.sv */
// Timer sequencer: holds both counts and runs a tick through the shared
// subtractor, with a restoring remainder loop for reload.
// Depends on sctsp_pkg and sctsp_alu.
module sctsp_timer_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sctsp_pkg::CYC_W-1:0]  elapsed_cycles,
  input  sctsp_pkg::tmr_ctl_t          ctl,
  input  logic [sctsp_pkg::TA_W-1:0]   value_a,
  input  logic [sctsp_pkg::TB_W-1:0]   value_b,
  output logic                         done,
  output sctsp_pkg::tmr_flag_t         flag_set
);
  import sctsp_pkg::*;

  typedef enum logic [5:0] {
    SQ_IDLE = 6'b000001,
    SQ_PICK = 6'b000010,
    SQ_CHK  = 6'b000100,
    SQ_DEC  = 6'b001000,
    SQ_MOD  = 6'b010000,
    SQ_RLD  = 6'b100000
  } sq_state_t;

  sq_state_t          state;
  logic               sel;
  logic [IDX_W-1:0]   idx;
  logic [CYC_W-1:0]   cyc;
  logic [CYC_W-1:0]   deficit;
  logic [CNT_W-1:0]   rem;
  logic [CNT_A_W-1:0] count_a;
  logic [CNT_B_W-1:0] count_b;
  logic [CNT_A_W-1:0] period_a;
  logic [CNT_B_W-1:0] period_b;
  logic [CNT_W-1:0]   per_sel;
  logic [UW-1:0]      cnt_ext;
  logic [UW-1:0]      trial;
  logic [UW-1:0]      op_a;
  logic [UW-1:0]      op_b;
  logic [UW-1:0]      diff;
  logic               borrow;

  assign period_a = period_a_f(value_a);
  assign period_b = period_b_f(value_b);
  assign per_sel  = sel ? period_b : CNT_W'(period_a);
  assign cnt_ext  = sel ? UW'(count_b) : UW'(count_a);
  assign trial    = {rem, deficit[idx]};

  always_comb begin
    unique case (state)
      SQ_CHK:  begin op_a = UW'(cyc);     op_b = cnt_ext;      end
      SQ_DEC:  begin op_a = cnt_ext;      op_b = UW'(cyc);     end
      SQ_MOD:  begin op_a = trial;        op_b = UW'(per_sel); end
      SQ_RLD:  begin op_a = UW'(per_sel); op_b = UW'(rem);     end
      default: begin op_a = '0;           op_b = '0;           end
    endcase
  end

  sctsp_alu u_alu (
    .a      (op_a),
    .b      (op_b),
    .diff   (diff),
    .borrow (borrow)
  );

  assign flag_set.a = (state == SQ_CHK) && !borrow && !sel;
  assign flag_set.b = (state == SQ_CHK) && !borrow && sel;
  assign done = sel && (((state == SQ_PICK) && !ctl.enables[sel]) ||
                        (state == SQ_DEC) || (state == SQ_RLD));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SQ_IDLE;
      sel     <= 1'b0;
      idx     <= '0;
      count_a <= '0;
      count_b <= '0;
    end else begin
      if (ctl.load_a) count_a <= period_a;
      if (ctl.load_b) count_b <= period_b;
      unique case (state)
        SQ_IDLE: begin
          if (start) begin
            cyc   <= sat_cycles(elapsed_cycles);
            sel   <= 1'b0;
            state <= SQ_PICK;
          end
        end
        SQ_PICK: begin
          if (ctl.enables[sel]) state <= SQ_CHK;
          else if (sel) state <= SQ_IDLE;
          else sel <= 1'b1;
        end
        SQ_CHK: begin
          // no borrow means the count ran to zero or below
          if (!borrow) begin
            deficit <= diff[CYC_W-1:0];
            rem     <= '0;
            idx     <= IDX_W'(CYC_W - 1);
            state   <= SQ_MOD;
          end else begin
            state <= SQ_DEC;
          end
        end
        SQ_MOD: begin
          rem <= borrow ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
          if (idx == '0) state <= SQ_RLD;
          else idx <= idx - 1'b1;
        end
        SQ_DEC, SQ_RLD: begin
          if (!sel) count_a <= diff[CNT_A_W-1:0];
          else count_b <= diff[CNT_B_W-1:0];
          if (sel) begin
            state <= SQ_IDLE;
          end else begin
            sel   <= 1'b1;
            state <= SQ_PICK;
          end
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

endmodule
